@@ hw/rtl/particle_pool_engine_core_assert.svh @@
// assertion macros for the particle pool engine
// the enclosing module provides clk and rst
`ifndef PARTICLE_POOL_ENGINE_CORE_ASSERT_SVH
`define PARTICLE_POOL_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("particle pool engine: same-cycle check failed");

`define PPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("particle pool engine: next-cycle check failed");

`else

`define PPE_ASSERT_IMP(lbl, ante, cons)

`define PPE_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/ppe_pkg.sv @@
`default_nettype none

package ppe_pkg;

  // command codes
  localparam logic [1:0] CMD_SPAWN = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_SPAWNED = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REPORT  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // one pool entry as stored in memory
  typedef struct packed {
    logic signed [19:0] place_x;
    logic signed [19:0] place_y;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic        [16:0] decay;
    logic signed [10:0] life;
    logic        [7:0]  alpha;
    logic        [7:0]  step;
    logic        [19:0] extent;
  } ppe_rec_t;

  // controller to datapath
  typedef struct packed {
    logic       in_ready;
    logic       load_item;
    logic       idx_clr;
    logic       idx_inc;
    logic       div_start;
    logic       ram_rd;
    logic       tick_calc;
    logic       tick_wr;
    logic       spawn_wr;
    logic       out_load;
    logic [1:0] out_status;
  } ppe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_cmd;
    logic       cur_used;
    logic       idx_end;
    logic       any_used;
    logic       div_done;
    logic       out_free;
  } ppe_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/ppe_item_if.sv @@
`default_nettype none

interface ppe_item_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic signed [19:0] start_x;
  logic signed [19:0] start_y;
  logic        [9:0]  sprite_w;
  logic        [9:0]  sprite_h;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [18:0] damping;
  logic signed [10:0] lifetime;
  logic signed [9:0]  opacity;

  modport source (
    output valid, cmd, start_x, start_y, sprite_w, sprite_h, vel_x, vel_y,
           damping, lifetime, opacity,
    input  ready
  );
  modport sink (
    input  valid, cmd, start_x, start_y, sprite_w, sprite_h, vel_x, vel_y,
           damping, lifetime, opacity,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/ppe_result_if.sv @@
`default_nettype none

interface ppe_result_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic        [5:0]  slot;
  logic signed [11:0] pix_x;
  logic signed [11:0] pix_y;
  logic        [9:0]  rep_w;
  logic        [9:0]  rep_h;
  logic        [7:0]  rep_alpha;
  logic               last;

  modport source (
    output valid, status, slot, pix_x, pix_y, rep_w, rep_h, rep_alpha, last,
    input  ready
  );
  modport sink (
    input  valid, status, slot, pix_x, pix_y, rep_w, rep_h, rep_alpha, last,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/ppe_ram.sv @@
`default_nettype none

module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [ADDR_W-1:0]      waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [ADDR_W-1:0]      raddr,
  output      logic [WIDTH-1:0]       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

@@ hw/rtl/ppe_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle; divide by zero returns the dividend
module ppe_div (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [9:0] divisor,
  output      logic [7:0] quotient,
  output      logic       done
);
  logic       busy;
  logic [2:0] cnt;
  logic [9:0] rem;
  logic [7:0] q;
  logic [7:0] dvd;
  logic [9:0] dsr;
  logic       by_zero;
  logic [10:0] trial;
  logic        ge;

  assign trial    = {rem, q[7]};
  assign ge       = trial >= {1'b0, dsr};
  assign quotient = by_zero ? dvd : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      q       <= dividend;
      dvd     <= dividend;
      dsr     <= divisor;
      by_zero <= (divisor == 10'd0);
    end else if (busy) begin
      rem <= ge ? 10'(trial - {1'b0, dsr}) : trial[9:0];
      q   <= {q[6:0], ge};
    end
  end
endmodule

`default_nettype wire

@@ hw/rtl/ppe_ctrl.sv @@
`default_nettype none

module ppe_ctrl
  import ppe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ppe_sts_t sts,
  output      ppe_cmd_t ctl
);
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SRCH     = 9'b000000010,
    S_SPAWN    = 9'b000000100,
    S_FULL     = 9'b000001000,
    S_EMPTY    = 9'b000010000,
    S_SWEEP    = 9'b000100000,
    S_TCALC    = 9'b001000000,
    S_TWR      = 9'b010000000,
    S_SCAN_OUT = 9'b100000000
  } ppe_state_t;

  ppe_state_t state, state_next;
  logic       is_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      is_tick <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_item) begin
        is_tick <= (sts.in_cmd == CMD_TICK);
      end
    end
  end

  always_comb begin
    ctl          = '0;
    ctl.in_ready = (state == S_IDLE);
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (sts.in_valid) begin
          ctl.load_item = 1'b1;
          ctl.idx_clr   = 1'b1;
          case (sts.in_cmd)
            CMD_SPAWN: begin
              ctl.div_start = 1'b1;
              state_next    = S_SRCH;
            end
            CMD_TICK: state_next = S_SWEEP;
            CMD_SCAN: state_next = sts.any_used ? S_SWEEP : S_EMPTY;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_SRCH: begin
        if (!sts.cur_used) begin
          state_next = S_SPAWN;
        end else if (sts.idx_end) begin
          state_next = S_FULL;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_SPAWN: begin
        if (sts.div_done && sts.out_free) begin
          ctl.spawn_wr   = 1'b1;
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_SPAWNED;
          state_next     = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_FULL;
          state_next     = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_EMPTY;
          state_next     = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sts.cur_used) begin
          ctl.ram_rd = 1'b1;
          state_next = is_tick ? S_TCALC : S_SCAN_OUT;
        end else if (sts.idx_end) begin
          state_next = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_TCALC: begin
        ctl.tick_calc = 1'b1;
        state_next    = S_TWR;
      end
      S_TWR: begin
        ctl.tick_wr = 1'b1;
        if (sts.idx_end) begin
          state_next = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_SWEEP;
        end
      end
      S_SCAN_OUT: begin
        if (sts.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = ST_REPORT;
          if (sts.idx_end) begin
            state_next = S_IDLE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_SWEEP;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

`default_nettype wire

@@ hw/rtl/ppe_dp.sv @@
`default_nettype none

module ppe_dp
  import ppe_pkg::*;
#(
  parameter int POOL_SLOTS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ppe_item_if.sink      item,
  ppe_result_if.source  result,
  input  wire ppe_cmd_t ctl,
  output      ppe_sts_t sts
);
  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int REC_W = $bits(ppe_rec_t);

  // accepted item
  logic signed [19:0] it_x;
  logic signed [19:0] it_y;
  logic        [9:0]  it_w;
  logic        [9:0]  it_h;
  logic signed [15:0] it_vx;
  logic signed [15:0] it_vy;
  logic signed [18:0] it_damp;
  logic signed [10:0] it_life;
  logic signed [9:0]  it_opac;

  logic [POOL_SLOTS-1:0] in_use;
  logic [IDX_W-1:0]      idx;
  logic [POOL_SLOTS-1:0] upper;

  logic [9:0] in_life_c;
  logic [7:0] in_alpha_c;
  logic [9:0] life_c;
  logic [7:0] alpha_c;
  logic [16:0] decay_c;
  logic [7:0] quot;
  logic       div_done;

  ppe_rec_t rd;
  ppe_rec_t wr;
  logic [REC_W-1:0] rdata;

  // tick pipeline registers
  logic signed [19:0] nx_px;
  logic signed [19:0] nx_py;
  logic        [33:0] prod_x;
  logic        [33:0] prod_y;
  logic        [7:0]  nx_alpha;
  logic signed [10:0] nx_life;

  logic [16:0] mag_x;
  logic [16:0] mag_y;
  logic signed [16:0] sp_x;
  logic signed [16:0] sp_y;

  // result register
  logic               out_valid;
  logic        [1:0]  o_status;
  logic        [5:0]  o_slot;
  logic signed [11:0] o_px;
  logic signed [11:0] o_py;
  logic        [9:0]  o_w;
  logic        [9:0]  o_h;
  logic        [7:0]  o_alpha;
  logic               o_last;

  function automatic logic signed [19:0] sat_add(logic signed [19:0] p,
                                                 logic signed [15:0] v);
    logic signed [20:0] s;
    s = 21'(p) + 21'(v);
    if (s[20] != s[19]) begin
      sat_add = s[20] ? 20'sh80000 : 20'sh7FFFF;
    end else begin
      sat_add = s[19:0];
    end
  endfunction

  function automatic logic signed [11:0] to_pix(logic signed [19:0] p);
    logic [20:0] mag;
    logic [20:0] sh;
    mag = p[19] ? (21'd0 - 21'(p)) : 21'(p);
    sh  = mag >> FRAC_BITS;
    if (p[19]) begin
      to_pix = (sh > 21'd2048) ? 12'sh800 : 12'(21'd0 - sh);
    end else begin
      to_pix = (sh > 21'd2047) ? 12'sh7FF : sh[11:0];
    end
  endfunction

  // spawn clamps
  assign in_life_c  = item.lifetime[10] ? 10'd0 : item.lifetime[9:0];
  assign in_alpha_c = item.opacity[9] ? 8'd0 : (item.opacity[8] ? 8'd255 : item.opacity[7:0]);
  assign life_c     = it_life[10] ? 10'd0 : it_life[9:0];
  assign alpha_c    = it_opac[9] ? 8'd0 : (it_opac[8] ? 8'd255 : it_opac[7:0]);
  always_comb begin
    if (it_damp[18]) begin
      decay_c = 17'd0;
    end else if (it_damp > 19'sd65536) begin
      decay_c = 17'd65536;
    end else begin
      decay_c = it_damp[16:0];
    end
  end

  ppe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (in_alpha_c),
    .divisor  (in_life_c),
    .quotient (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      it_x    <= item.start_x;
      it_y    <= item.start_y;
      it_w    <= item.sprite_w;
      it_h    <= item.sprite_h;
      it_vx   <= item.vel_x;
      it_vy   <= item.vel_y;
      it_damp <= item.damping;
      it_life <= item.lifetime;
      it_opac <= item.opacity;
    end
  end

  // slot index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  assign rd = ppe_rec_t'(rdata);

  // tick arithmetic
  assign mag_x = rd.speed_x[15] ? (17'd0 - 17'(rd.speed_x)) : 17'(rd.speed_x);
  assign mag_y = rd.speed_y[15] ? (17'd0 - 17'(rd.speed_y)) : 17'(rd.speed_y);

  always_ff @(posedge clk) begin
    if (ctl.tick_calc) begin
      nx_px    <= sat_add(rd.place_x, rd.speed_x);
      nx_py    <= sat_add(rd.place_y, rd.speed_y);
      prod_x   <= 34'(mag_x) * 34'(rd.decay);
      prod_y   <= 34'(mag_y) * 34'(rd.decay);
      nx_alpha <= (rd.step > rd.alpha) ? 8'd0 : 8'(rd.alpha - rd.step);
      nx_life  <= rd.life - 11'sd1;
    end
  end

  // damped speed: shrink magnitude by magnitude times decay, shifted right by 16
  assign sp_x = rd.speed_x[15] ? (17'(rd.speed_x) + 17'(prod_x[32:16]))
                               : (17'(rd.speed_x) - 17'(prod_x[32:16]));
  assign sp_y = rd.speed_y[15] ? (17'(rd.speed_y) + 17'(prod_y[32:16]))
                               : (17'(rd.speed_y) - 17'(prod_y[32:16]));

  always_comb begin
    if (ctl.spawn_wr) begin
      wr.place_x = it_x;
      wr.place_y = it_y;
      wr.speed_x = it_vx;
      wr.speed_y = it_vy;
      wr.decay   = decay_c;
      wr.life    = {1'b0, life_c};
      wr.alpha   = alpha_c;
      wr.step    = quot;
      wr.extent  = {it_h, it_w};
    end else begin
      wr.place_x = nx_px;
      wr.place_y = nx_py;
      wr.speed_x = sp_x[15:0];
      wr.speed_y = sp_y[15:0];
      wr.decay   = rd.decay;
      wr.life    = nx_life;
      wr.alpha   = nx_alpha;
      wr.step    = rd.step;
      wr.extent  = rd.extent;
    end
  end

  ppe_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.spawn_wr | ctl.tick_wr),
    .waddr (idx),
    .wdata (wr),
    .re    (ctl.ram_rd),
    .raddr (idx),
    .rdata (rdata)
  );

  // occupancy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (ctl.spawn_wr) begin
      in_use[idx] <= 1'b1;
    end else if (ctl.tick_wr && nx_life[10]) begin
      in_use[idx] <= 1'b0;
    end
  end

  assign upper = in_use >> idx;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      o_status <= ctl.out_status;
      o_slot   <= '0;
      o_px     <= '0;
      o_py     <= '0;
      o_w      <= '0;
      o_h      <= '0;
      o_alpha  <= '0;
      o_last   <= 1'b1;
      case (ctl.out_status)
        ST_SPAWNED: o_slot <= 6'(idx);
        ST_REPORT: begin
          o_slot  <= 6'(idx);
          o_px    <= to_pix(rd.place_x);
          o_py    <= to_pix(rd.place_y);
          o_w     <= rd.extent[9:0];
          o_h     <= rd.extent[19:10];
          o_alpha <= rd.alpha;
          o_last  <= ((upper >> 1) == '0);
        end
        default: o_slot <= '0;
      endcase
    end
  end

  assign item.ready       = ctl.in_ready;
  assign result.valid     = out_valid;
  assign result.status    = o_status;
  assign result.slot      = o_slot;
  assign result.pix_x     = o_px;
  assign result.pix_y     = o_py;
  assign result.rep_w     = o_w;
  assign result.rep_h     = o_h;
  assign result.rep_alpha = o_alpha;
  assign result.last      = o_last;

  always_comb begin
    sts.in_valid = item.valid;
    sts.in_cmd   = item.cmd;
    sts.cur_used = in_use[idx];
    sts.idx_end  = (idx == IDX_W'(POOL_SLOTS - 1));
    sts.any_used = |in_use;
    sts.div_done = div_done;
    sts.out_free = !out_valid || result.ready;
  end
endmodule

`default_nettype wire

@@ hw/rtl/particle_pool_engine_core.sv @@
// channel   dir  beat contents
// --------  ---  ------------------------------------------------------------
// item      in   cmd, start_x/y, sprite_w/h, vel_x/y, damping, lifetime, opacity
// result    out  status, slot, pix_x/y, rep_w/h, rep_alpha, last
//
// spawn: lowest-free search walks the occupancy bits one slot a cycle while
//   the alpha step divider runs; the slot is written once the divider is done
// tick: free slots are skipped; a used slot is read, multiplied and written back
// scan: free slots are skipped; a used slot is read, then reported, plus result-side stalls
// reset clears the occupancy bits at once, no clearing pass over the memory
// a result beat waiting on a stalled sink never blocks the next item accept
`default_nettype none

module particle_pool_engine_core
  import ppe_pkg::*;
#(
  parameter int POOL_SLOTS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ppe_item_if.sink     item,
  ppe_result_if.source result
);

`include "particle_pool_engine_core_assert.svh"

  ppe_cmd_t ctl;
  ppe_sts_t sts;

  // sequencer: command decode, slot sweeps, result handoff
  ppe_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  // slot memory, occupancy bits, tick arithmetic, divider and result register
  ppe_dp #(
    .POOL_SLOTS (POOL_SLOTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .ctl    (ctl),
    .sts    (sts)
  );

  // a result is only loaded when the output register is free
  `PPE_ASSERT_IMP(a_out_load_free, ctl.out_load, sts.out_free)

  // a spawn only writes a slot that is free
  `PPE_ASSERT_IMP(a_spawn_free_slot, ctl.spawn_wr, !sts.cur_used)

  // a real command makes the block busy on the following cycle
  `PPE_ASSERT_NXT(a_busy_after_cmd, item.valid && item.ready && (item.cmd != CMD_NONE), !item.ready)

endmodule

`default_nettype wire
